FILE: rtl/nki_pkg.sv
// Shared types and constants for the nearest knot interpolator.
package nki_pkg;

  localparam int MaxKnots  = 256;
  localparam int ValueBits = 32;
  localparam int IdxBits   = $clog2(MaxKnots);
  localparam int CountBits = IdxBits + 1;

  localparam logic [CountBits-1:0] KnotCountReset = CountBits'(MaxKnots);
  localparam logic [CountBits-1:0] KnotCountMin   = CountBits'(2);
  localparam logic [CountBits-1:0] KnotCountMax   = CountBits'(MaxKnots);

  localparam logic [1:0] CMD_POS   = 2'd0;
  localparam logic [1:0] CMD_VAL   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_CMP,
    ST_LO,
    ST_PICK,
    ST_OUT
  } state_e;

  // one access to a knot table
  typedef struct packed {
    logic                 we;
    logic [IdxBits-1:0]   addr;
    logic [ValueBits-1:0] wdata;
  } ram_req_t;

endpackage

FILE: rtl/nki_ram.sv
// Single-port synchronous RAM, registered read data.
module nki_ram #(
  parameter int Depth = 256,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

FILE: rtl/nki_seq.sv
// Command sequencer: table writes, interval search and nearest-knot pick.
module nki_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd_i,
  input  logic [nki_pkg::IdxBits-1:0]      knot_index_i,
  input  logic [nki_pkg::ValueBits-1:0]    write_data_i,
  input  logic [nki_pkg::ValueBits-1:0]    query_x_i,
  input  logic                             restart_i,
  input  logic [nki_pkg::IdxBits-1:0]      last_i,
  output nki_pkg::ram_req_t                pos_req_o,
  output nki_pkg::ram_req_t                val_req_o,
  input  logic [nki_pkg::ValueBits-1:0]    pos_rdata_i,
  input  logic [nki_pkg::ValueBits-1:0]    val_rdata_i,
  output logic                             result_valid_o,
  output logic [nki_pkg::ValueBits-1:0]    result_value_o,
  output logic                             in_range_o
);

  nki_pkg::state_e state_q, state_d;

  logic [nki_pkg::IdxBits-1:0]   ptr_q, ptr_d;
  logic [nki_pkg::IdxBits-1:0]   ptr_base, ptr_new, ptr_inc, ptr_inc2;
  logic [nki_pkg::ValueBits-1:0] x_q, x_d;
  logic [nki_pkg::ValueBits-1:0] x2_q, x2_d;
  logic                          below_q, below_d;
  logic [nki_pkg::ValueBits:0]   dlo_q, dlo_d;
  logic [nki_pkg::ValueBits:0]   dhi_q, dhi_d;
  logic                          valid_q, valid_d;
  logic [nki_pkg::ValueBits-1:0] value_q, value_d;
  logic                          inr_q, inr_d;
  logic                          x_lt_rd;

  assign ptr_base = restart_i ? '0 : ptr_q;
  assign ptr_new  = (ptr_base > last_i) ? last_i : ptr_base;
  assign ptr_inc  = ptr_q + 1'b1;
  assign ptr_inc2 = ptr_q + 2'd2;
  assign x_lt_rd  = $signed(x_q) < $signed(pos_rdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nki_pkg::ST_IDLE;
      ptr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    x2_q    <= x2_d;
    below_q <= below_d;
    dlo_q   <= dlo_d;
    dhi_q   <= dhi_d;
    value_q <= value_d;
    inr_q   <= inr_d;
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    x_d       = x_q;
    x2_d      = x2_q;
    below_d   = below_q;
    dlo_d     = dlo_q;
    dhi_d     = dhi_q;
    valid_d   = 1'b0;
    value_d   = value_q;
    inr_d     = inr_q;
    pos_req_o = '0;
    val_req_o = '0;
    unique case (state_q)
      nki_pkg::ST_IDLE: begin
        pos_req_o.addr  = knot_index_i;
        pos_req_o.wdata = write_data_i;
        val_req_o.addr  = knot_index_i;
        val_req_o.wdata = write_data_i;
        if (start) begin
          if (cmd_i == nki_pkg::CMD_POS) begin
            pos_req_o.we = 1'b1;
          end else if (cmd_i == nki_pkg::CMD_VAL) begin
            val_req_o.we = 1'b1;
          end else if (cmd_i == nki_pkg::CMD_QUERY) begin
            x_d   = query_x_i;
            ptr_d = ptr_new;
            if (ptr_new == last_i) begin
              valid_d = 1'b1;
              value_d = '0;
              inr_d   = 1'b0;
            end else begin
              state_d = nki_pkg::ST_NEXT;
            end
          end
        end
      end
      nki_pkg::ST_NEXT: begin
        pos_req_o.addr = ptr_inc;
        state_d        = nki_pkg::ST_CMP;
      end
      nki_pkg::ST_CMP: begin
        // read data is the knot above the current interval
        if (!x_lt_rd) begin
          ptr_d = ptr_inc;
          if (ptr_inc == last_i) begin
            valid_d = 1'b1;
            value_d = '0;
            inr_d   = 1'b0;
            state_d = nki_pkg::ST_IDLE;
          end else begin
            pos_req_o.addr = ptr_inc2;
          end
        end else begin
          x2_d           = pos_rdata_i;
          pos_req_o.addr = ptr_q;
          state_d        = nki_pkg::ST_LO;
        end
      end
      nki_pkg::ST_LO: begin
        below_d = x_lt_rd;
        dlo_d   = {x_q[nki_pkg::ValueBits-1], x_q}
                - {pos_rdata_i[nki_pkg::ValueBits-1], pos_rdata_i};
        dhi_d   = {x2_q[nki_pkg::ValueBits-1], x2_q}
                - {x_q[nki_pkg::ValueBits-1], x_q};
        state_d = nki_pkg::ST_PICK;
      end
      nki_pkg::ST_PICK: begin
        // tie keeps the lower knot
        val_req_o.addr = (!below_q && (dlo_q > dhi_q)) ? ptr_inc : ptr_q;
        state_d        = nki_pkg::ST_OUT;
      end
      nki_pkg::ST_OUT: begin
        valid_d = 1'b1;
        value_d = val_rdata_i;
        inr_d   = 1'b1;
        state_d = nki_pkg::ST_IDLE;
      end
      default: begin
        state_d = nki_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != nki_pkg::ST_IDLE);
  assign result_valid_o = valid_q;
  assign result_value_o = value_q;
  assign in_range_o     = inr_q;

  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nki_pkg::ST_OUT |=> valid_q && inr_q)
    else $error("result after table read not flagged in range");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !inr_q |-> value_q == '0)
    else $error("out of range result carries nonzero value");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == nki_pkg::ST_IDLE)
    else $error("result strobe while search still running");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nki_pkg::ST_CMP && !x_lt_rd |=> ptr_q == $past(ptr_inc))
    else $error("interval pointer did not advance by one");

endmodule

FILE: rtl/nearest_knot_interpolator.sv
// Top level of the nearest knot interpolator: config register, sequencer and knot tables.
//
// Usage: commands enter on start when busy is low. cmd 0 writes a knot position,
// cmd 1 a knot value (index knot_index_i, data write_data_i); both give no result
// and leave busy low. cmd 3 is ignored. cmd 2 is a query at query_x_i; restart_i
// rewinds the interval pointer first. Queries within a run must ascend.
// A query result appears on result_value_o / in_range_o, marked by
// result_valid_o for one cycle; there is no back pressure. A query that finds
// the pointer already on the last knot strobes without going busy. Any other
// query goes busy while the pointer steps over knots, with one position-table
// read per step plus one; a query whose pointer steps onto the last knot then
// strobes. Otherwise there follow one read of the lower knot position, the
// distance compare with one value-table read, and the registered result.
// The next command is taken at the end of the strobe cycle at the earliest.
// knot_count is written through knot_count_we_i; the user must write it only
// while idle, which the block itself does not enforce. Reset sets it to 256
// and clears the pointer. Table contents are undefined until written.
module nearest_knot_interpolator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             knot_count_we_i,
  input  logic [nki_pkg::CountBits-1:0]    knot_count_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd_i,
  input  logic [nki_pkg::IdxBits-1:0]      knot_index_i,
  input  logic [nki_pkg::ValueBits-1:0]    write_data_i,
  input  logic [nki_pkg::ValueBits-1:0]    query_x_i,
  input  logic                             restart_i,
  output logic                             result_valid_o,
  output logic [nki_pkg::ValueBits-1:0]    result_value_o,
  output logic                             in_range_o
);

  logic [nki_pkg::CountBits-1:0] knot_count_q, knot_count_d;
  logic [nki_pkg::CountBits-1:0] used_knots, last_full;
  logic [nki_pkg::IdxBits-1:0]   last;
  nki_pkg::ram_req_t             pos_req, val_req;
  logic [nki_pkg::ValueBits-1:0] pos_rdata, val_rdata;

  assign knot_count_d = knot_count_we_i ? knot_count_i : knot_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= nki_pkg::KnotCountReset;
    end else begin
      knot_count_q <= knot_count_d;
    end
  end

  assign used_knots = (knot_count_q < nki_pkg::KnotCountMin) ? nki_pkg::KnotCountMin :
                      (knot_count_q > nki_pkg::KnotCountMax) ? nki_pkg::KnotCountMax :
                      knot_count_q;
  assign last_full  = used_knots - 1'b1;
  assign last       = last_full[nki_pkg::IdxBits-1:0];

  nki_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .knot_index_i  (knot_index_i),
    .write_data_i  (write_data_i),
    .query_x_i     (query_x_i),
    .restart_i     (restart_i),
    .last_i        (last),
    .pos_req_o     (pos_req),
    .val_req_o     (val_req),
    .pos_rdata_i   (pos_rdata),
    .val_rdata_i   (val_rdata),
    .result_valid_o(result_valid_o),
    .result_value_o(result_value_o),
    .in_range_o    (in_range_o)
  );

  nki_ram #(
    .Depth(nki_pkg::MaxKnots),
    .Width(nki_pkg::ValueBits)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_req.we),
    .addr_i (pos_req.addr),
    .wdata_i(pos_req.wdata),
    .rdata_o(pos_rdata)
  );

  nki_ram #(
    .Depth(nki_pkg::MaxKnots),
    .Width(nki_pkg::ValueBits)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_req.we),
    .addr_i (val_req.addr),
    .wdata_i(val_req.wdata),
    .rdata_o(val_rdata)
  );

endmodule
